// ----- design/nhr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhr_pkg: shared types and constants
// Command codes, register indexes and widths for the n-gram row id block.
// ----------------------------------------------------------------------------
package nhr_pkg;

   localparam int MaxHeads   = 8;
   localparam int HeadBits   = 3;
   localparam int TokenBits  = 32;
   localparam int ModBits    = 32;
   localparam int OffBits    = 40;
   localparam int RowBits    = 41;
   localparam int ValBits    = 64;

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_HASH = 2'd1,
      CMD_LOAD = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_MULT_CUR  = 3'd0,
      CSR_MULT_PREV = 3'd1,
      CSR_MULT_PRV2 = 3'd2,
      CSR_EOS       = 3'd3,
      CSR_HEADS     = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_READ,
      ST_DIV,
      ST_FIX,
      ST_OUT
   } state_type;

endpackage

// ----- design/ngram_hash_row_ids_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngram_hash_row_ids_top: hashed n-gram row index generator
// Usage:
//   req_ beats carry a command (push context, hash, load head entry).
//   A hash beat yields one rsp_ beat per active head; rsp_tlast marks the
//   final head. Push and load beats yield no rsp_ beat.
//   Head modulus and offset live in one 8-entry synchronous memory with a
//   registered read; entries must be loaded before use.
//   csr_ writes set multipliers, eos id and active head count; the user
//   must write them only while idle, as the block does not enforce it.
// Operation:
//   Push and load beats are taken while idle. A hash forms the bigram and
//   trigram (64x32 products split in two 32x32 halves), then per head runs
//   the remainder (magnitude load, overlapping the memory read, and 64
//   radix-2 restoring steps), a fix step and an output step. The next req_
//   beat is taken only after the rsp_ beat of the final head is taken.
// Reset: window tokens clear, active heads return to 8, multipliers and
//   eos clear. The head memory is not cleared.
// Stall: while rsp_tready is low the result beat holds and work pauses.
// ----------------------------------------------------------------------------
module ngram_hash_row_ids_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[1:0], token[33:2], head_select[36:34], head_modulus_in[68:37],
   // head_offset_in[108:69], zero fill [111:109]
   input  logic [111:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // row_id[40:0], head[43:41], zero fill [47:44]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // configuration
   logic [63:0] mcur_ff, mprev_ff, mprv2_ff;
   logic [31:0] eos_ff;
   logic [3:0]  heads_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mcur_ff <= '0; mprev_ff <= '0; mprv2_ff <= '0;
         eos_ff <= '0; heads_cfg_ff <= 4'd8;
      end else if (csr_wen) begin
         case (csr_index)
            nhr_pkg::CSR_MULT_CUR:  mcur_ff  <= csr_wdata;
            nhr_pkg::CSR_MULT_PREV: mprev_ff <= csr_wdata;
            nhr_pkg::CSR_MULT_PRV2: mprv2_ff <= csr_wdata;
            nhr_pkg::CSR_EOS:       eos_ff   <= csr_wdata[31:0];
            nhr_pkg::CSR_HEADS:     heads_cfg_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   logic [1:0]  in_cmd;
   logic [31:0] in_tok;
   logic [2:0]  in_sel;
   logic [31:0] in_mod;
   logic [39:0] in_off;
   assign in_cmd = req_tdata[1:0];
   assign in_tok = req_tdata[33:2];
   assign in_sel = req_tdata[36:34];
   assign in_mod = req_tdata[68:37];
   assign in_off = req_tdata[108:69];

   // head table memory: {offset, modulus}
   logic [71:0] head_mem [nhr_pkg::MaxHeads];
   logic [71:0] mem_rd_ff;
   logic [2:0]  head_ff, head_in;

   nhr_pkg::state_type state_ff, state_in;
   logic accept;
   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (accept && in_cmd == nhr_pkg::CMD_LOAD) begin
         head_mem[in_sel] <= {in_off, in_mod};
      end
      mem_rd_ff <= head_mem[head_ff];
   end

   // datapath registers
   logic [31:0] prev_ff, prev2_ff, tok_ff, ctx2_ff;
   logic [63:0] big_ff, big_in, tri_ff, tri_in;
   logic [63:0] plo_ff, plo_in;   // previous-token low-half product
   logic [1:0]  step_ff, step_in;
   logic [63:0] dvd_ff, dvd_in;   // shifting magnitude
   logic [32:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [3:0]  heads_ff, heads_in;
   logic [40:0] row_ff, row_in;
   logic        last_ff, last_in;

   // token * multiplier split: low and high 32-bit halves of multiplier
   logic [31:0] ma, mb;
   logic [63:0] prod;
   assign prod = {32'd0, ma} * {32'd0, mb};

   logic [63:0] val;
   logic [32:0] rtry;
   logic [31:0] modv;
   logic [39:0] offv;
   assign modv = mem_rd_ff[31:0];
   assign offv = mem_rd_ff[71:32];
   assign rtry = {rem_ff[31:0], dvd_ff[63]} - {1'b0, modv};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nhr_pkg::ST_IDLE;
         prev_ff <= '0; prev2_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && (in_cmd == nhr_pkg::CMD_PUSH || in_cmd == nhr_pkg::CMD_HASH)) begin
            prev2_ff <= prev_ff;
            prev_ff  <= in_tok;
         end
      end
      if (accept) begin
         tok_ff  <= in_tok;
         ctx2_ff <= (prev_ff == eos_ff) ? eos_ff : prev2_ff;
      end
      big_ff <= big_in; tri_ff <= tri_in; plo_ff <= plo_in; step_ff <= step_in;
      dvd_ff <= dvd_in; rem_ff <= rem_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
      heads_ff <= heads_in; head_ff <= head_in; row_ff <= row_in; last_ff <= last_in;
   end

   logic [31:0] prev_cur;  // previous token as of the hash beat
   assign prev_cur = prev2_ff;

   always_comb begin
      state_in = state_ff;
      big_in = big_ff; tri_in = tri_ff; plo_in = plo_ff; step_in = step_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; cnt_in = cnt_ff; neg_in = neg_ff;
      heads_in = heads_ff; head_in = head_ff; row_in = row_ff; last_in = last_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      ma = '0; mb = '0;
      val = ({1'b0, head_ff} < {1'b0, heads_ff[3:1]}) ? big_ff : tri_ff;
      case (state_ff)
         nhr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && in_cmd == nhr_pkg::CMD_HASH) begin
               state_in = nhr_pkg::ST_MUL;
               step_in = '0; big_in = '0; tri_in = '0;
               head_in = '0;
               if (heads_cfg_ff == 4'd0) heads_in = 4'd1;
               else if (heads_cfg_ff > 4'd8) heads_in = 4'd8;
               else heads_in = heads_cfg_ff;
            end
         end
         nhr_pkg::ST_MUL: begin
            // two half products per term: low then high half of multiplier
            case (step_ff)
               2'd0: begin ma = tok_ff;  mb = mcur_ff[31:0];  end
               2'd1: begin ma = prev_cur; mb = mprev_ff[31:0]; end
               2'd2: begin ma = ctx2_ff; mb = mprv2_ff[31:0]; end
               default: begin ma = '0; mb = '0; end
            endcase
            // hold the previous-token low product until its high half comes
            case (step_ff)
               2'd0: big_in = prod;
               2'd1: plo_in = prod;
               2'd2: tri_in = prod;
               default: ;
            endcase
            if (step_ff == 2'd2) state_in = nhr_pkg::ST_READ;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) step_in = '0;
         end
         nhr_pkg::ST_READ: begin
            // add high-half contributions, one term per cycle, then form the trigram
            case (step_ff)
               2'd0: begin ma = tok_ff;  mb = mcur_ff[63:32];  end
               2'd1: begin ma = prev_cur; mb = mprev_ff[63:32]; end
               2'd2: begin ma = ctx2_ff; mb = mprv2_ff[63:32]; end
               default: begin ma = '0; mb = '0; end
            endcase
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0: big_in = big_ff + {prod[31:0], 32'd0};
               2'd1: big_in = big_ff ^ (plo_ff + {prod[31:0], 32'd0});
               2'd2: tri_in = tri_ff + {prod[31:0], 32'd0};
               default: begin
                  tri_in = big_ff ^ tri_ff;
                  state_in = nhr_pkg::ST_DIV;
                  cnt_in = '0;
               end
            endcase
         end
         nhr_pkg::ST_DIV: begin
            // cnt 0: memory read data is registered; load magnitude
            if (cnt_ff == 7'd0) begin
               neg_in = val[63];
               dvd_in = val[63] ? (~val + 64'd1) : val;
               rem_in = '0;
               cnt_in = 7'd1;
            end else begin
               if (!rtry[32]) rem_in = rtry;
               else rem_in = {rem_ff[31:0], dvd_ff[63]};
               dvd_in = {dvd_ff[62:0], 1'b0};
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff == 7'd64) state_in = nhr_pkg::ST_FIX;
            end
         end
         nhr_pkg::ST_FIX: begin
            if (modv == '0) row_in = {1'b0, offv};
            else if (neg_ff && rem_ff[31:0] != '0)
               row_in = {9'd0, modv - rem_ff[31:0]} + {1'b0, offv};
            else row_in = {9'd0, rem_ff[31:0]} + {1'b0, offv};
            last_in = ({1'b0, head_ff} + 4'd1 == heads_ff);
            state_in = nhr_pkg::ST_OUT;
         end
         nhr_pkg::ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (last_ff) state_in = nhr_pkg::ST_IDLE;
               else begin
                  head_in = head_ff + 3'd1;
                  cnt_in = '0;
                  state_in = nhr_pkg::ST_DIV;
               end
            end
         end
         default: state_in = nhr_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tdata = {4'd0, head_ff, row_ff};
   assign rsp_tlast = last_ff;

endmodule

// ----- tb/sv/ngram_hash_row_ids_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngram_hash_row_ids_checker: row id predictor and response scoreboard
// Watches the csr, req and rsp channels of the n-gram row id block, keeps its
// own token window, head table and register copy, predicts the row id beats
// of every hash command and compares them in order with the rsp beats.
// ----------------------------------------------------------------------------
module ngram_hash_row_ids_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [47:0]  rsp_tdata,
   input  logic         rsp_tlast,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   output int           fail_count,
   output int           rows_pending
);

   typedef struct packed {
      logic [nhr_pkg::RowBits-1:0]  row_id;
      logic [nhr_pkg::HeadBits-1:0] head;
      logic                         last;
   } row_beat_type;

   localparam int ExpDepth = 16;

   // expected beats in order; write and read counts wrap over the store
   row_beat_type exp_mem[ExpDepth];
   int           exp_wr;
   int           exp_rd;

   logic [63:0]                 mul_cur, mul_prev, mul_prv2;
   logic [31:0]                 eos_id;
   logic [3:0]                  heads_cfg;
   logic [31:0]                 win_prev, win_prev2;
   logic [nhr_pkg::ModBits-1:0] mod_tab[nhr_pkg::MaxHeads];
   logic [nhr_pkg::OffBits-1:0] off_tab[nhr_pkg::MaxHeads];

   // floor modulo of a signed 64-bit value by an unsigned modulus
   function automatic logic [63:0] signed_floor_mod(logic [63:0] v, logic [31:0] m);
      logic [63:0] mag;
      logic [63:0] r;
      if (m == 0) return 64'd0;
      if (!v[63]) return v % {32'd0, m};
      mag = ~v + 64'd1;
      r = mag % {32'd0, m};
      return (r == 0) ? 64'd0 : {32'd0, m} - r;
   endfunction

   task automatic predict_rows(logic [31:0] tok);
      logic [63:0]  bigram, trigram, ctx2, val, sum;
      int           nheads;
      row_beat_type rb;
      ctx2 = (win_prev == eos_id) ? {32'd0, eos_id} : {32'd0, win_prev2};
      bigram = ({32'd0, tok} * mul_cur) ^ ({32'd0, win_prev} * mul_prev);
      trigram = bigram ^ (ctx2 * mul_prv2);
      nheads = (heads_cfg == 0) ? 1 :
               (heads_cfg > nhr_pkg::MaxHeads) ? nhr_pkg::MaxHeads : int'(heads_cfg);
      for (int h = 0; h < nheads; h++) begin
         val = (h < nheads / 2) ? bigram : trigram;
         sum = signed_floor_mod(val, mod_tab[h]) + {24'd0, off_tab[h]};
         rb.row_id = sum[nhr_pkg::RowBits-1:0];
         rb.head = h[nhr_pkg::HeadBits-1:0];
         rb.last = (h + 1 == nheads);
         exp_mem[4'(exp_wr)] = rb;
         exp_wr++;
      end
   endtask

   always @(posedge clock) begin
      row_beat_type     got, want;
      nhr_pkg::cmd_type cmd;
      if (reset) begin
         mul_cur = '0;
         mul_prev = '0;
         mul_prv2 = '0;
         eos_id = '0;
         heads_cfg = 4'd8;
         win_prev = '0;
         win_prev2 = '0;
         exp_wr = 0;
         exp_rd = 0;
         fail_count = 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               nhr_pkg::CSR_MULT_CUR:  mul_cur = csr_wdata;
               nhr_pkg::CSR_MULT_PREV: mul_prev = csr_wdata;
               nhr_pkg::CSR_MULT_PRV2: mul_prv2 = csr_wdata;
               nhr_pkg::CSR_EOS:       eos_id = csr_wdata[31:0];
               nhr_pkg::CSR_HEADS:     heads_cfg = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.row_id = rsp_tdata[40:0];
            got.head = rsp_tdata[43:41];
            got.last = rsp_tlast;
            if (exp_wr == exp_rd) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t checker: unexpected rsp beat row %0d head %0d last %0b",
                           $realtime, got.row_id, got.head, got.last);
            end else begin
               want = exp_mem[4'(exp_rd)];
               exp_rd++;
               if (got.row_id !== want.row_id || got.head !== want.head ||
                   got.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t checker: mismatch exp row %0d head %0d last %0b,",
                               " got row %0d head %0d last %0b"},
                              $realtime, want.row_id, want.head, want.last,
                              got.row_id, got.head, got.last);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            cmd = nhr_pkg::cmd_type'(req_tdata[1:0]);
            case (cmd)
               nhr_pkg::CMD_LOAD: begin
                  mod_tab[req_tdata[36:34]] = req_tdata[68:37];
                  off_tab[req_tdata[36:34]] = req_tdata[108:69];
               end
               nhr_pkg::CMD_PUSH: begin
                  win_prev2 = win_prev;
                  win_prev = req_tdata[33:2];
               end
               nhr_pkg::CMD_HASH: begin
                  predict_rows(req_tdata[33:2]);
                  win_prev2 = win_prev;
                  win_prev = req_tdata[33:2];
               end
               default: ;
            endcase
         end
      end
      rows_pending = exp_wr - exp_rd;
   end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: n-gram row id block testbench
// Loads the head table, then runs directed hash and context beats over the
// register extremes and several random phases of push/hash sequences with
// bursty req traffic and a stalling rsp side; the checker scores responses.
// ----------------------------------------------------------------------------
module tb;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [47:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_wen;
   logic [2:0]   csr_index;
   logic [63:0]  csr_wdata;
   int           fail_count;
   int           rows_pending;

   logic [31:0]  cur_eos;
   int           burst_left;
   logic         hold_req;
   int           idle_cycles;

   ngram_hash_row_ids_top u_dut (.*);

   ngram_hash_row_ids_checker u_chk (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver: stall pattern is redrawn from three modes, with one long hold-off
   initial begin
      int cnt;
      int mode;
      bit held;
      rsp_tready = 1'b0;
      cnt = 0;
      mode = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !held) begin
            held = 1'b1;
            rsp_tready = 1'b0;
            repeat (1500) @(negedge clock);
         end else begin
            if (++cnt == 150) begin
               cnt = 0;
               mode = $urandom_range(0, 2);
            end
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = ($urandom_range(0, 99) < 70);
               default: rsp_tready = ($urandom_range(0, 99) < 25);
            endcase
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= 6000) begin
         $display("tb: done, errors");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic logic [111:0] pack_req(nhr_pkg::cmd_type cmd, logic [31:0] tok,
                                              logic [2:0] sel, logic [31:0] md,
                                              logic [39:0] off);
      return {3'b000, off, md, sel, tok, cmd};
   endfunction

   function automatic logic [63:0] pick_mult();
      case ($urandom_range(0, 7))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return '1;
         3: return 64'd1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [31:0] pick_token();
      case ($urandom_range(0, 7))
         0, 1: return cur_eos;
         2: return 32'd0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_modulus();
      case ($urandom_range(0, 5))
         0: return 32'd1;
         1: return '1;
         2: return $urandom_range(2, 64);
         default: return $urandom | 32'd1;
      endcase
   endfunction

   task automatic send_beat(logic [111:0] data);
      if (burst_left == 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   // drop valid and hold until every expected row has come back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (rows_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic csr_write(nhr_pkg::csr_idx_type idx, logic [63:0] val);
      @(negedge clock);
      csr_wen = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx == nhr_pkg::CSR_EOS) cur_eos = val[31:0];
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   task automatic hash(logic [31:0] tok);
      send_beat(pack_req(nhr_pkg::CMD_HASH, tok, '0, '0, '0));
   endtask

   task automatic push(logic [31:0] tok);
      send_beat(pack_req(nhr_pkg::CMD_PUSH, tok, '0, '0, '0));
   endtask

   task automatic load_head(logic [2:0] sel, logic [31:0] md, logic [39:0] off);
      send_beat(pack_req(nhr_pkg::CMD_LOAD, '0, sel, md, off));
   endtask

   initial begin
      logic [31:0] mods[8];
      logic [39:0] offs[8];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cur_eos = '0;
      burst_left = 0;
      hold_req = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill every head entry; one entry gets the zero modulus case
      mods = '{32'd1, '1, 32'd0, 32'd7, 32'd1000, 32'h8000_0001, 32'd3, 32'h1234_5679};
      offs = '{40'd0, '1, 40'd17, 40'h55_5555_5555, 40'haa_aaaa_aaaa, 40'd1, 40'd100, '1};
      for (int i = 0; i < 8; i++) load_head(i[2:0], mods[i], offs[i]);
      hash(32'd3);

      wait_idle();
      csr_write(nhr_pkg::CSR_MULT_CUR, '1);
      csr_write(nhr_pkg::CSR_MULT_PREV, 64'h8000_0000_0000_0000);
      csr_write(nhr_pkg::CSR_MULT_PRV2, 64'h7fff_ffff_ffff_ffff);
      csr_write(nhr_pkg::CSR_EOS, 64'd5);
      csr_write(nhr_pkg::CSR_HEADS, 64'd8);
      push(32'd5);
      hash(32'd9);
      push(32'd0);
      hash('1);
      hash(32'd5);
      send_beat(pack_req(nhr_pkg::CMD_NONE, '1, '1, '1, '1));
      hash(32'd0);

      wait_idle();
      csr_write(nhr_pkg::CSR_HEADS, 64'd0);
      hash(32'd77);
      wait_idle();
      csr_write(nhr_pkg::CSR_HEADS, 64'd15);
      csr_write(nhr_pkg::csr_idx_type'(3'd5), '1);
      hash(32'h8000_0000);
      wait_idle();
      csr_write(nhr_pkg::CSR_HEADS, 64'd1);
      hash(32'd1);
      wait_idle();
      csr_write(nhr_pkg::CSR_HEADS, 64'd3);
      csr_write(nhr_pkg::CSR_EOS, '1);
      push('1);
      hash(32'd2);

      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         csr_write(nhr_pkg::CSR_MULT_CUR, pick_mult());
         csr_write(nhr_pkg::CSR_MULT_PREV, pick_mult());
         csr_write(nhr_pkg::CSR_MULT_PRV2, pick_mult());
         csr_write(nhr_pkg::CSR_EOS,
                   64'((ph == 2) ? 32'd0 : (ph == 4) ? 32'hffff_ffff : $urandom));
         csr_write(nhr_pkg::CSR_HEADS,
                   (ph == 1) ? 64'd1 : (ph == 3) ? 64'd8 : 64'($urandom_range(0, 15)));
         for (int n = 0; n < 50; n++) begin
            int r;
            r = $urandom_range(0, 99);
            if (ph == 3 && n == 10) hold_req = 1'b1;
            if (r < 40) push(pick_token());
            else if (r < 80) hash(pick_token());
            else if (r < 93)
               load_head(3'($urandom_range(0, 7)), pick_modulus(),
                         40'({$urandom, $urandom}));
            else
               send_beat(pack_req(nhr_pkg::CMD_NONE, $urandom, 3'($urandom), $urandom,
                                  40'({$urandom, $urandom})));
         end
      end

      wait_idle();
      repeat (600) @(posedge clock);
      if (fail_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
